/* src/owbm_pkg.sv */
package owbm_pkg;

  localparam int REG_W    = 10;
  localparam int NUM_REGS = 8;
  localparam int IDX_W    = 3;

  typedef logic [REG_W-1:0] reg_val_t;
  typedef logic [IDX_W-1:0] reg_idx_t;

  // Timing register indexes on the configuration port.
  localparam reg_idx_t REG_RST_LOW     = 3'd0;
  localparam reg_idx_t REG_RST_SAMPLE  = 3'd1;
  localparam reg_idx_t REG_RST_RECOVER = 3'd2;
  localparam reg_idx_t REG_WR_SHORT    = 3'd3;
  localparam reg_idx_t REG_WR_LONG     = 3'd4;
  localparam reg_idx_t REG_RD_LOW      = 3'd5;
  localparam reg_idx_t REG_RD_SAMPLE   = 3'd6;
  localparam reg_idx_t REG_RD_RECOVER  = 3'd7;

  localparam reg_val_t REG_RESET [NUM_REGS] = '{
    10'd420, 10'd50, 10'd350, 10'd1, 10'd46, 10'd5, 10'd1, 10'd42
  };

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_RST_LOW  = 9'b000000010,
    PH_RST_WAIT = 9'b000000100,
    PH_RST_REC  = 9'b000001000,
    PH_W_FIRST  = 9'b000010000,
    PH_W_SECOND = 9'b000100000,
    PH_R_LOW    = 9'b001000000,
    PH_R_SAMPLE = 9'b010000000,
    PH_R_REC    = 9'b100000000
  } phase_t;

endpackage

/* src/owbm_if.sv */
interface owbm_in_if;
  import owbm_pkg::*;

  logic       valid;
  logic       ready;
  op_t        opcode;
  logic [7:0] write_data;
  logic       bus_level;

  modport source (output valid, opcode, write_data, bus_level, input ready);
  modport sink   (input valid, opcode, write_data, bus_level, output ready);
endinterface

interface owbm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       presence;
  logic       rejected;

  modport source (output valid, drive_low, busy_res, done_res, read_data, presence,
                  rejected, input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, read_data, presence,
                  rejected, output ready);
endinterface

/* src/one_wire_bus_master.sv */
// Single-wire bus master. Every input transaction is one microsecond tick and
// yields exactly one result transaction, one per clock cycle sustained: the
// phase sequencer updates on the accepting edge and the result sits in an output
// register, so a new tick is taken whenever that register is empty or being
// emptied. A reset, write or read command is started only while idle; a command
// during an operation is flagged rejected and counts as a plain tick. The eight
// phase lengths are set via cfg_, by the user only while idle (not enforced);
// a zero length acts as one, lengths past the counter range clip to its top.
module one_wire_bus_master #(
  parameter int COUNTER_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  owbm_pkg::reg_idx_t cfg_index,
  input  owbm_pkg::reg_val_t cfg_wdata,
  owbm_in_if.sink            in_ch,
  owbm_out_if.source         out_ch
);
  import owbm_pkg::*;

  localparam int SW = (COUNTER_BITS > REG_W) ? COUNTER_BITS : REG_W;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
  localparam logic [SW-1:0] CNT_MAX_W = SW'(CNT_MAX);

  reg_val_t                cfg_r [NUM_REGS];
  phase_t                  phase_r, phase_nxt;
  logic [COUNTER_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [2:0]              bit_r, bit_nxt;
  logic [7:0]              shift_r, shift_nxt;
  logic                    pres_r, pres_nxt;
  logic                    line_r, line_nxt;
  logic [7:0]              last_r, last_nxt;

  logic       out_valid_r;
  logic       out_done_r, out_rej_r;
  logic       done_c, rej_c;
  logic       in_acc, active;
  reg_idx_t   len_idx;
  logic [SW-1:0] len_raw, len;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_r[i] <= REG_RESET[i];
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  always_comb begin
    active  = 1'b1;
    len_idx = REG_RST_LOW;
    unique case (phase_r)
      PH_RST_LOW:  len_idx = REG_RST_LOW;
      PH_RST_WAIT: len_idx = REG_RST_SAMPLE;
      PH_RST_REC:  len_idx = REG_RST_RECOVER;
      PH_W_FIRST:  len_idx = shift_r[0] ? REG_WR_SHORT : REG_WR_LONG;
      PH_W_SECOND: len_idx = shift_r[0] ? REG_WR_LONG : REG_WR_SHORT;
      PH_R_LOW:    len_idx = REG_RD_LOW;
      PH_R_SAMPLE: len_idx = REG_RD_SAMPLE;
      PH_R_REC:    len_idx = REG_RD_RECOVER;
      default:     active  = 1'b0;
    endcase
  end

  always_comb begin
    len_raw = SW'(cfg_r[len_idx]);
    if (len_raw == '0) begin
      len = SW'(1);
    end else if (len_raw > CNT_MAX_W) begin
      len = CNT_MAX_W;
    end else begin
      len = len_raw;
    end
    cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    line_nxt  = line_r;
    last_nxt  = last_r;
    done_c    = 1'b0;
    rej_c     = 1'b0;
    if (in_acc) begin
      if (!active) begin
        phase_nxt = PH_IDLE;
        line_nxt  = 1'b0;
        cnt_nxt   = '0;
        case (in_ch.opcode)
          OP_RESET: begin
            phase_nxt = PH_RST_LOW;
            line_nxt  = 1'b1;
          end
          OP_WRITE: begin
            phase_nxt = PH_W_FIRST;
            line_nxt  = 1'b1;
            shift_nxt = in_ch.write_data;
            bit_nxt   = '0;
          end
          OP_READ: begin
            phase_nxt = PH_R_LOW;
            line_nxt  = 1'b1;
            shift_nxt = '0;
            bit_nxt   = '0;
          end
          default: ;
        endcase
      end else begin
        rej_c   = (in_ch.opcode != OP_TICK);
        cnt_nxt = cnt_inc;
        if (SW'(cnt_inc) >= len) begin
          // Phase over: every branch restarts the count with the new phase.
          cnt_nxt  = '0;
          line_nxt = 1'b0;
          unique case (phase_r)
            PH_RST_LOW:  phase_nxt = PH_RST_WAIT;
            PH_RST_WAIT: begin
              pres_nxt  = !in_ch.bus_level;
              phase_nxt = PH_RST_REC;
            end
            PH_W_FIRST:  phase_nxt = PH_W_SECOND;
            PH_W_SECOND: begin
              shift_nxt = shift_r >> 1;
              bit_nxt   = bit_r + 1'b1;
              if (bit_r == 3'd7) begin
                phase_nxt = PH_IDLE;
                done_c    = 1'b1;
              end else begin
                phase_nxt = PH_W_FIRST;
                line_nxt  = 1'b1;
              end
            end
            PH_R_LOW:    phase_nxt = PH_R_SAMPLE;
            PH_R_SAMPLE: begin
              shift_nxt = shift_r | (8'(in_ch.bus_level) << bit_r);
              phase_nxt = PH_R_REC;
            end
            PH_R_REC: begin
              bit_nxt = bit_r + 1'b1;
              if (bit_r == 3'd7) begin
                last_nxt  = shift_r;
                phase_nxt = PH_IDLE;
                done_c    = 1'b1;
              end else begin
                phase_nxt = PH_R_LOW;
                line_nxt  = 1'b1;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
              done_c    = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      pres_r      <= 1'b0;
      line_r      <= 1'b0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
      out_done_r  <= 1'b0;
      out_rej_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      pres_r  <= pres_nxt;
      line_r  <= line_nxt;
      last_r  <= last_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
        out_done_r  <= done_c;
        out_rej_r   <= rej_c;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The state registers hold exactly what the last transaction left behind.
  assign out_ch.valid     = out_valid_r;
  assign out_ch.drive_low = line_r;
  assign out_ch.busy_res  = (phase_r != PH_IDLE);
  assign out_ch.done_res  = out_done_r;
  assign out_ch.read_data = last_r;
  assign out_ch.presence  = pres_r;
  assign out_ch.rejected  = out_rej_r;

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(phase_r) && $stable(cnt_r) && $stable(shift_r))
    else $error("sequencer state moved without an input transaction");

  a_busy_reject: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && active && in_ch.opcode != OP_TICK |=> out_rej_r && out_valid_r)
    else $error("command during an operation not flagged as rejected");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_IDLE |=> !out_done_r && !out_rej_r)
    else $error("done or rejected raised on a transaction taken while idle");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && done_c |=> phase_r == PH_IDLE && !line_r)
    else $error("operation finished without returning to idle with the line released");

endmodule
